// ----- rtl/rkfd_pkg.sv -----
package rkfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KEY_BYTES   = 5;
    localparam int unsigned KEY_W       = KEY_BYTES * BYTE_W;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = KEY_W;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned EVENT_W     = 3;
    localparam int unsigned ALARM_W     = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ID_KEY             = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEAD         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_LEARN          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_BATTERY_STOLEN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_STOLEN         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_RAISED         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_FELL           = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_WIRE_BROKEN    = 3'd7;

    // register reset values
    localparam logic [KEY_W-1:0]  RST_ID_KEY             = '0;
    localparam logic [BYTE_W-1:0] RST_FRAME_HEAD         = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CMD_LEARN          = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CMD_BATTERY_STOLEN = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CMD_STOLEN         = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CMD_RAISED         = 8'd4;
    localparam logic [BYTE_W-1:0] RST_CMD_FELL           = 8'd5;
    localparam logic [BYTE_W-1:0] RST_CMD_WIRE_BROKEN    = 8'd6;

    // alarm bit positions
    localparam int unsigned ALM_STOLEN  = 0;
    localparam int unsigned ALM_RAISED  = 1;
    localparam int unsigned ALM_FELL    = 2;
    localparam int unsigned ALM_WIRE    = 3;
    localparam int unsigned ALM_BATTERY = 4;

    // frame positions
    localparam logic [POS_W-1:0] POS_FIRST   = 3'd0;
    localparam logic [POS_W-1:0] POS_SECOND  = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST_ID = 3'd4;
    localparam logic [POS_W-1:0] POS_CMD     = 3'd5;
    localparam logic [POS_W-1:0] POS_LEARN_END = 3'd6;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE       = 3'd0,
        EV_BATTERY    = 3'd1,
        EV_STOLEN     = 3'd2,
        EV_RAISED     = 3'd3,
        EV_FELL       = 3'd4,
        EV_WIRE       = 3'd5,
        EV_LEARN_DONE = 3'd6
    } event_t;

    typedef struct packed {
        logic [KEY_W-1:0]  id_key;
        logic [BYTE_W-1:0] frame_head;
        logic [BYTE_W-1:0] cmd_learn;
        logic [BYTE_W-1:0] cmd_battery_stolen;
        logic [BYTE_W-1:0] cmd_stolen;
        logic [BYTE_W-1:0] cmd_raised;
        logic [BYTE_W-1:0] cmd_fell;
        logic [BYTE_W-1:0] cmd_wire_broken;
    } cfg_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
        logic              learn_mode;
    } item_t;

    typedef struct packed {
        event_t             event_res;
        logic               magnet_toggle;
        logic [ALARM_W-1:0] pending;
    } result_t;

endpackage

// ----- rtl/rkfd_if.sv -----
interface rkfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [rkfd_pkg::BYTE_W-1:0] rx_byte;
    logic                       learn_mode;

    modport source (output valid, output op, output rx_byte, output learn_mode, input ready);
    modport sink (input valid, input op, input rx_byte, input learn_mode, output ready);
endinterface

interface rkfd_result_if;
    logic                         valid;
    logic                         ready;
    logic [rkfd_pkg::EVENT_W-1:0] event_res;
    logic                         magnet_toggle;
    logic                         pending_stolen;
    logic                         pending_raised;
    logic                         pending_fell;
    logic                         pending_wire;
    logic                         pending_battery;

    modport source (
        output valid, output event_res, output magnet_toggle,
        output pending_stolen, output pending_raised, output pending_fell,
        output pending_wire, output pending_battery,
        input ready
    );
    modport sink (
        input valid, input event_res, input magnet_toggle,
        input pending_stolen, input pending_raised, input pending_fell,
        input pending_wire, input pending_battery,
        output ready
    );
endinterface

// ----- rtl/rkfd_cfg_regs.sv -----
module rkfd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rkfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rkfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rkfd_pkg::cfg_t                   cfg
);

    rkfd_pkg::cfg_t cfg_reg;
    logic [rkfd_pkg::BYTE_W-1:0] data_byte;

    assign data_byte = cfg_data[rkfd_pkg::BYTE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.id_key             <= rkfd_pkg::RST_ID_KEY;
            cfg_reg.frame_head         <= rkfd_pkg::RST_FRAME_HEAD;
            cfg_reg.cmd_learn          <= rkfd_pkg::RST_CMD_LEARN;
            cfg_reg.cmd_battery_stolen <= rkfd_pkg::RST_CMD_BATTERY_STOLEN;
            cfg_reg.cmd_stolen         <= rkfd_pkg::RST_CMD_STOLEN;
            cfg_reg.cmd_raised         <= rkfd_pkg::RST_CMD_RAISED;
            cfg_reg.cmd_fell           <= rkfd_pkg::RST_CMD_FELL;
            cfg_reg.cmd_wire_broken    <= rkfd_pkg::RST_CMD_WIRE_BROKEN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rkfd_pkg::REG_ID_KEY:             cfg_reg.id_key <= cfg_data[rkfd_pkg::KEY_W-1:0];
                rkfd_pkg::REG_FRAME_HEAD:         cfg_reg.frame_head <= data_byte;
                rkfd_pkg::REG_CMD_LEARN:          cfg_reg.cmd_learn <= data_byte;
                rkfd_pkg::REG_CMD_BATTERY_STOLEN: cfg_reg.cmd_battery_stolen <= data_byte;
                rkfd_pkg::REG_CMD_STOLEN:         cfg_reg.cmd_stolen <= data_byte;
                rkfd_pkg::REG_CMD_RAISED:         cfg_reg.cmd_raised <= data_byte;
                rkfd_pkg::REG_CMD_FELL:           cfg_reg.cmd_fell <= data_byte;
                rkfd_pkg::REG_CMD_WIRE_BROKEN:    cfg_reg.cmd_wire_broken <= data_byte;
                default:                          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/rkfd_frame_fsm.sv -----
module rkfd_frame_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rkfd_pkg::item_t   item,
    input  rkfd_pkg::cfg_t    cfg,
    output rkfd_pkg::result_t result
);

    logic [rkfd_pkg::POS_W-1:0]   pos_reg;
    logic [rkfd_pkg::POS_W-1:0]   pos_next;
    logic [rkfd_pkg::ALARM_W-1:0] alarm_reg;
    logic [rkfd_pkg::ALARM_W-1:0] alarm_next;
    logic                         prev_learn_reg;

    logic [rkfd_pkg::POS_W-1:0]   pos_cur;
    logic [rkfd_pkg::BYTE_W-1:0]  key_byte;
    logic [rkfd_pkg::ALARM_W-1:0] alarm_cmd;
    rkfd_pkg::event_t             cmd_event;
    rkfd_pkg::event_t             event_val;
    logic                         magnet;

    // entering learning mode restarts the frame
    assign pos_cur = (item.learn_mode && !prev_learn_reg) ? rkfd_pkg::POS_FIRST : pos_reg;

    always_comb
    begin
        case (pos_cur)
            3'd0:    key_byte = cfg.id_key[39:32];
            3'd1:    key_byte = cfg.id_key[31:24];
            3'd2:    key_byte = cfg.id_key[23:16];
            3'd3:    key_byte = cfg.id_key[15:8];
            3'd4:    key_byte = cfg.id_key[7:0];
            default: key_byte = '0;
        endcase
    end

    // command decode, battery first, then stolen, raised, fell, wire
    always_comb
    begin
        alarm_cmd = alarm_reg;
        cmd_event = rkfd_pkg::EV_NONE;
        if (item.rx_byte == cfg.cmd_battery_stolen)
        begin
            alarm_cmd[rkfd_pkg::ALM_BATTERY] = 1'b1;
            cmd_event = rkfd_pkg::EV_BATTERY;
        end
        else if (item.rx_byte == cfg.cmd_stolen)
        begin
            alarm_cmd[rkfd_pkg::ALM_STOLEN] = 1'b1;
            alarm_cmd[rkfd_pkg::ALM_RAISED] = 1'b0;
            alarm_cmd[rkfd_pkg::ALM_FELL]   = 1'b0;
            cmd_event = rkfd_pkg::EV_STOLEN;
        end
        else if (item.rx_byte == cfg.cmd_raised)
        begin
            alarm_cmd[rkfd_pkg::ALM_STOLEN] = 1'b0;
            alarm_cmd[rkfd_pkg::ALM_RAISED] = 1'b1;
            alarm_cmd[rkfd_pkg::ALM_FELL]   = 1'b0;
            cmd_event = rkfd_pkg::EV_RAISED;
        end
        else if (item.rx_byte == cfg.cmd_fell)
        begin
            alarm_cmd[rkfd_pkg::ALM_STOLEN] = 1'b0;
            alarm_cmd[rkfd_pkg::ALM_RAISED] = 1'b0;
            alarm_cmd[rkfd_pkg::ALM_FELL]   = 1'b1;
            cmd_event = rkfd_pkg::EV_FELL;
        end
        else if (item.rx_byte == cfg.cmd_wire_broken)
        begin
            alarm_cmd[rkfd_pkg::ALM_WIRE] = 1'b1;
            cmd_event = rkfd_pkg::EV_WIRE;
        end
    end

    always_comb
    begin
        pos_next   = pos_cur;
        alarm_next = alarm_reg;
        event_val  = rkfd_pkg::EV_NONE;
        magnet     = 1'b0;
        if (item.op)
        begin
            alarm_next = '0;
        end
        else if (!item.learn_mode)
        begin
            if (pos_cur <= rkfd_pkg::POS_LAST_ID && item.rx_byte == key_byte)
            begin
                pos_next = pos_cur + 3'd1;
                magnet   = (pos_cur == rkfd_pkg::POS_SECOND);
            end
            else if (pos_cur == rkfd_pkg::POS_CMD)
            begin
                pos_next   = rkfd_pkg::POS_FIRST;
                alarm_next = alarm_cmd;
                event_val  = cmd_event;
            end
            else
            begin
                pos_next = rkfd_pkg::POS_FIRST;
            end
        end
        else
        begin
            if (pos_cur == rkfd_pkg::POS_FIRST)
            begin
                pos_next = (item.rx_byte == cfg.frame_head) ? rkfd_pkg::POS_SECOND
                                                            : rkfd_pkg::POS_FIRST;
            end
            else if (pos_cur == rkfd_pkg::POS_SECOND)
            begin
                pos_next = (item.rx_byte == cfg.cmd_learn) ? 3'd2 : rkfd_pkg::POS_FIRST;
            end
            else if (pos_cur <= rkfd_pkg::POS_CMD)
            begin
                pos_next = pos_cur + 3'd1;
            end
            else if (pos_cur == rkfd_pkg::POS_LEARN_END)
            begin
                pos_next  = rkfd_pkg::POS_FIRST;
                event_val = rkfd_pkg::EV_LEARN_DONE;
            end
            else
            begin
                pos_next = rkfd_pkg::POS_FIRST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= rkfd_pkg::POS_FIRST;
            alarm_reg      <= '0;
            prev_learn_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg        <= pos_next;
            alarm_reg      <= alarm_next;
            prev_learn_reg <= item.learn_mode;
        end
    end

    // a service transfer reports the alarms as they were before clearing
    assign result.event_res     = event_val;
    assign result.magnet_toggle = magnet;
    assign result.pending       = item.op ? alarm_reg : alarm_next;

endmodule

// ----- rtl/remote_key_frame_decoder.sv -----
// remote key frame decoder
// datapath: input register, then combinational decode into the result register
// throughput: one item per cycle unless result_ch.ready stalls the output
// reset: rst_n asynchronous active low; clears frame position, pending alarms,
//        learn mode history and both valid flags, and loads register defaults
module remote_key_frame_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [rkfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rkfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    rkfd_byte_if.sink                        byte_ch,
    rkfd_result_if.source                    result_ch
);

    rkfd_pkg::cfg_t    cfg;
    rkfd_pkg::item_t   item_reg;
    logic              item_valid_reg;
    rkfd_pkg::result_t result_val;
    rkfd_pkg::result_t result_reg;
    logic              result_valid_reg;
    logic              advance;
    logic              step;

    assign advance       = !result_valid_reg || result_ch.ready;
    assign step          = item_valid_reg && advance;
    assign byte_ch.ready = !item_valid_reg || advance;

    rkfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rkfd_frame_fsm u_frame_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ch.ready)
            begin
                item_valid_reg <= byte_ch.valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            item_reg.op         <= byte_ch.op;
            item_reg.rx_byte    <= byte_ch.rx_byte;
            item_reg.learn_mode <= byte_ch.learn_mode;
        end
        if (step)
        begin
            result_reg <= result_val;
        end
    end

    assign result_ch.valid           = result_valid_reg;
    assign result_ch.event_res       = result_reg.event_res;
    assign result_ch.magnet_toggle   = result_reg.magnet_toggle;
    assign result_ch.pending_stolen  = result_reg.pending[rkfd_pkg::ALM_STOLEN];
    assign result_ch.pending_raised  = result_reg.pending[rkfd_pkg::ALM_RAISED];
    assign result_ch.pending_fell    = result_reg.pending[rkfd_pkg::ALM_FELL];
    assign result_ch.pending_wire    = result_reg.pending[rkfd_pkg::ALM_WIRE];
    assign result_ch.pending_battery = result_reg.pending[rkfd_pkg::ALM_BATTERY];

endmodule

// ----- rtl/rkfd_checker.sv -----
module rkfd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input logic [rkfd_pkg::EVENT_W-1:0] event_res,
    input logic                         magnet_toggle,
    input logic                         pending_stolen,
    input logic                         pending_raised,
    input logic                         pending_fell,
    input logic                         pending_wire,
    input logic                         pending_battery
);

    // a stalled result keeps valid, its event and its magnet toggle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(event_res) && $stable(magnet_toggle))
        else $error("result changed while stalled");

    // stolen, raised and fell exclude one another
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $onehot0({pending_stolen, pending_raised, pending_fell}))
        else $error("more than one of stolen raised fell pending");

    // magnet pulse only on an id byte, never with an event
    a_magnet: assert property (@(posedge clk) disable iff (!rst_n)
        valid && magnet_toggle |-> event_res == rkfd_pkg::EV_NONE)
        else $error("magnet toggle together with an event");

    // a latched alarm shows as pending in the same transfer
    a_latch: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (event_res != rkfd_pkg::EV_BATTERY || pending_battery)
               && (event_res != rkfd_pkg::EV_WIRE || pending_wire)
               && (event_res != rkfd_pkg::EV_STOLEN || pending_stolen)
               && (event_res != rkfd_pkg::EV_RAISED || pending_raised)
               && (event_res != rkfd_pkg::EV_FELL || pending_fell))
        else $error("event without its pending alarm");

    // no unused event code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> event_res <= rkfd_pkg::EV_LEARN_DONE)
        else $error("event code out of range");

endmodule

bind remote_key_frame_decoder rkfd_checker u_rkfd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (result_ch.valid),
    .ready           (result_ch.ready),
    .event_res       (result_ch.event_res),
    .magnet_toggle   (result_ch.magnet_toggle),
    .pending_stolen  (result_ch.pending_stolen),
    .pending_raised  (result_ch.pending_raised),
    .pending_fell    (result_ch.pending_fell),
    .pending_wire    (result_ch.pending_wire),
    .pending_battery (result_ch.pending_battery)
);
